// File: rtl/core/windowed_colormap_lookup_macros.svh
// Assertion macros used by the checker of the windowed colormap lookup.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef WINDOWED_COLORMAP_LOOKUP_MACROS_SVH
`define WINDOWED_COLORMAP_LOOKUP_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define WCL_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define WCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequence that must hold in the cycle after reset was seen low.
`define WCL_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/wcl_pkg.sv
// Shared types and constants of the windowed colormap lookup.
// No dependencies; every module of the block imports it.
package wcl_pkg;

    localparam int WCL_PALETTE_BITS = 16;
    localparam int WCL_DATA_BITS    = 32;

    // Depth of the queue between front and back, and of the result buffer.
    localparam int WCL_QUEUE_DEPTH = 4;
    localparam int WCL_OUT_DEPTH   = 8;

    localparam int CFG_WIDTH     = 32;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int COLOR_WIDTH   = 32;
    localparam int FRAC_BITS     = 16;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DATA_MIN = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DATA_MAX = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SCALE    = 2'd2;

    localparam logic [CFG_WIDTH-1:0] CFG_MIN_RESET   = 32'h0000_0000;
    localparam logic [CFG_WIDTH-1:0] CFG_MAX_RESET   = 32'h0000_ffff;
    localparam logic [CFG_WIDTH-1:0] CFG_SCALE_RESET = 32'h0001_0000;

    typedef enum logic [1:0] {
        REGION_BELOW  = 2'd0,
        REGION_INSIDE = 2'd1,
        REGION_ABOVE  = 2'd2
    } t_region;

    typedef struct packed {
        logic                     we;
        logic [CFG_IDX_WIDTH-1:0] index;
        logic [CFG_WIDTH-1:0]     data;
    } t_cfg_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

// File: rtl/core/wcl_fifo.sv
// Small synchronous FIFO used as the front-to-back queue and the result buffer.
// Depends on wcl_pkg for the status struct.
module wcl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output wcl_pkg::t_fifo_status        o_status,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import wcl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_count != CW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_count        = r_count;
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// File: rtl/core/wcl_front.sv
// Front end: accepts requests, holds the window bounds and classifies samples.
// Depends on wcl_pkg; feeds the front-to-back queue.
module wcl_front #(
    parameter int DATA_BITS    = 32,
    parameter int PALETTE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wcl_pkg::t_cfg_wr               i_cfg,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_mode,
    input  logic signed [DATA_BITS-1:0]    i_sample,
    input  logic [PALETTE_BITS-1:0]        i_entry_index,
    input  logic [wcl_pkg::COLOR_WIDTH-1:0] i_entry_color,
    input  logic                           i_last_pixel,
    output logic                           o_push,
    input  logic                           i_full,
    output logic                           o_write,
    output wcl_pkg::t_region               o_region,
    output logic                           o_last,
    output logic [DATA_BITS-1:0]           o_diff,
    output logic [PALETTE_BITS-1:0]        o_addr,
    output logic [wcl_pkg::COLOR_WIDTH-1:0] o_color
);
    import wcl_pkg::*;

    logic signed [DATA_BITS-1:0] r_data_min;
    logic signed [DATA_BITS-1:0] r_data_max;

    logic                     r_valid;
    logic                     n_valid;
    logic                     r_write;
    t_region                  r_region;
    logic                     r_last;
    logic [DATA_BITS-1:0]     r_diff;
    logic [PALETTE_BITS-1:0]  r_addr;
    logic [COLOR_WIDTH-1:0]   r_color;

    logic                     advance;
    logic                     take;
    logic [DATA_BITS:0]       diff_full;
    t_region                  region_c;

    // The stage moves on when it is empty or its request enters the queue.
    assign advance = !r_valid || !i_full;
    assign take    = i_valid && advance;
    assign o_stall = !advance;

    // Difference of two in-range values of the data width, sign-extended by one bit.
    assign diff_full = {i_sample[DATA_BITS-1], i_sample}
                     - {r_data_min[DATA_BITS-1], r_data_min};

    // The upper bound is tested first, so a sample >= data_max yields the top entry.
    always_comb begin
        priority if (i_sample >= r_data_max) begin
            region_c = REGION_ABOVE;
        end else if (i_sample > r_data_min) begin
            region_c = REGION_INSIDE;
        end else begin
            region_c = REGION_BELOW;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (advance) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_min <= CFG_MIN_RESET[DATA_BITS-1:0];
            r_data_max <= CFG_MAX_RESET[DATA_BITS-1:0];
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg.we && (i_cfg.index == CFG_DATA_MIN)) begin
                r_data_min <= i_cfg.data[DATA_BITS-1:0];
            end
            if (i_cfg.we && (i_cfg.index == CFG_DATA_MAX)) begin
                r_data_max <= i_cfg.data[DATA_BITS-1:0];
            end
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_write  <= i_mode;
            r_region <= region_c;
            r_last   <= i_last_pixel;
            r_diff   <= diff_full[DATA_BITS-1:0];
            r_addr   <= i_entry_index;
            r_color  <= i_entry_color;
        end
    end

    assign o_push   = r_valid && !i_full;
    assign o_write  = r_write;
    assign o_region = r_region;
    assign o_last   = r_last;
    assign o_diff   = r_diff;
    assign o_addr   = r_addr;
    assign o_color  = r_color;

endmodule

// File: rtl/core/wcl_back.sv
// Back end: scales the window offset, performs palette writes and reads.
// Depends on wcl_pkg; drains the queue and fills the result buffer.
module wcl_back #(
    parameter int DATA_BITS    = 32,
    parameter int PALETTE_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  wcl_pkg::t_cfg_wr                            i_cfg,
    input  logic                                        i_empty,
    output logic                                        o_pop,
    input  logic                                        i_write,
    input  wcl_pkg::t_region                            i_region,
    input  logic                                        i_last,
    input  logic [DATA_BITS-1:0]                        i_diff,
    input  logic [PALETTE_BITS-1:0]                     i_addr,
    input  logic [wcl_pkg::COLOR_WIDTH-1:0]             i_color,
    input  logic [$clog2(wcl_pkg::WCL_OUT_DEPTH+1)-1:0] i_out_count,
    output logic                                        o_valid,
    output logic [wcl_pkg::COLOR_WIDTH-1:0]             o_color,
    output wcl_pkg::t_region                            o_region,
    output logic                                        o_last
);
    import wcl_pkg::*;

    localparam int PAL_DEPTH = 2 ** PALETTE_BITS;
    localparam int PW        = DATA_BITS + CFG_WIDTH;
    localparam int CW        = $clog2(WCL_OUT_DEPTH + 1);
    localparam int SW        = CW + 1;
    localparam int IDX_TOP   = FRAC_BITS + PALETTE_BITS;

    logic [CFG_WIDTH-1:0]    r_scale;

    logic                    r_b1_valid;
    logic                    r_b1_write;
    t_region                 r_b1_region;
    logic                    r_b1_last;
    logic [DATA_BITS-1:0]    r_b1_diff;
    logic [PALETTE_BITS-1:0] r_b1_addr;
    logic [COLOR_WIDTH-1:0]  r_b1_color;

    logic                    r_b2_valid;
    logic                    r_b2_write;
    t_region                 r_b2_region;
    logic                    r_b2_last;
    logic [PW-1:0]           r_b2_prod;
    logic [PALETTE_BITS-1:0] r_b2_addr;
    logic [COLOR_WIDTH-1:0]  r_b2_color;

    logic                    r_b3_valid;
    t_region                 r_b3_region;
    logic                    r_b3_last;
    logic [COLOR_WIDTH-1:0]  r_rd_data;

    logic [COLOR_WIDTH-1:0]  r_palette [PAL_DEPTH];

    logic [SW-1:0]           reserved;
    logic                    pop;
    logic [PW-1:0]           prod_c;
    logic                    idx_sat;
    logic [PALETTE_BITS-1:0] rd_addr;

    function automatic logic [PW-1:0] i_diff_mul(input logic [DATA_BITS-1:0] a,
                                                 input logic [CFG_WIDTH-1:0] b);
        logic [PW-1:0] p;
        p = {{CFG_WIDTH{1'b0}}, a} * {{DATA_BITS{1'b0}}, b};
        return p;
    endfunction

    // The back end never stalls, so a request leaves the queue only while the
    // result buffer has room for everything already in flight plus this one.
    assign reserved = SW'(i_out_count) + SW'(r_b1_valid) + SW'(r_b2_valid) + SW'(r_b3_valid);
    assign pop      = !i_empty && (reserved < SW'(WCL_OUT_DEPTH));
    assign o_pop    = pop;

    assign prod_c  = i_diff_mul(r_b1_diff, r_scale);
    assign idx_sat = |r_b2_prod[PW-1:IDX_TOP];

    always_comb begin
        unique case (r_b2_region)
            REGION_BELOW:  rd_addr = '0;
            REGION_INSIDE: rd_addr = idx_sat ? '1 : r_b2_prod[IDX_TOP-1:FRAC_BITS];
            REGION_ABOVE:  rd_addr = '1;
            default:       rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= CFG_SCALE_RESET;
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
        end else begin
            if (i_cfg.we && (i_cfg.index == CFG_SCALE)) begin
                r_scale <= i_cfg.data;
            end
            r_b1_valid <= pop;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid && !r_b2_write;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_write  <= i_write;
        r_b1_region <= i_region;
        r_b1_last   <= i_last;
        r_b1_diff   <= i_diff;
        r_b1_addr   <= i_addr;
        r_b1_color  <= i_color;

        r_b2_write  <= r_b1_write;
        r_b2_region <= r_b1_region;
        r_b2_last   <= r_b1_last;
        r_b2_prod   <= prod_c;
        r_b2_addr   <= r_b1_addr;
        r_b2_color  <= r_b1_color;

        r_b3_region <= r_b2_region;
        r_b3_last   <= r_b2_last;
    end

    // Writes and reads pass the same stage in request order, so a read sees
    // every earlier write and none of the later ones.
    always_ff @(posedge i_clk) begin
        if (r_b2_valid && r_b2_write) begin
            r_palette[r_b2_addr] <= r_b2_color;
        end
        if (r_b2_valid && !r_b2_write) begin
            r_rd_data <= r_palette[rd_addr];
        end
    end

    assign o_valid  = r_b3_valid;
    assign o_color  = r_rd_data;
    assign o_region = r_b3_region;
    assign o_last   = r_b3_last;

endmodule

// File: rtl/core/windowed_colormap_lookup.sv
// Windowed colormap lookup, top level.
// Depends on wcl_pkg, wcl_front, wcl_fifo and wcl_back.
//
// Usage: the request channel (i_valid / o_stall) carries either a palette
// write (i_mode high: i_entry_color is stored at i_entry_index) or a pixel
// (i_mode low: i_sample is mapped). A request is taken at a clock edge where
// i_valid is high and o_stall is low. Each pixel yields one result on the
// output channel (o_valid / i_stall) holding the palette color, the window
// region and a copy of the last-pixel mark; palette writes yield nothing.
// Results come out in request order.
// Each pixel passes the input register, queue, back-end stages and result buffer.
// Throughput: one request per cycle, sustained while i_stall stays low, set
// by the single palette port that serves one write or one read each cycle.
// When the receiver stalls, the result holds; up to eight results are
// buffered, then the queue and input stage fill and o_stall rises.
// Reset (synchronous, active low) empties all stages and restores the
// window registers; the palette content is undefined until written.
// Configuration writes (data_min, data_max, scale) take effect at once. The
// user makes them only while the block is idle; the block does not check it.
module windowed_colormap_lookup #(
    parameter int PALETTE_BITS = wcl_pkg::WCL_PALETTE_BITS,
    parameter int DATA_BITS    = wcl_pkg::WCL_DATA_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wcl_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  logic [wcl_pkg::CFG_WIDTH-1:0]       i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_mode,
    input  logic signed [DATA_BITS-1:0]         i_sample,
    input  logic [PALETTE_BITS-1:0]             i_entry_index,
    input  logic [wcl_pkg::COLOR_WIDTH-1:0]     i_entry_color,
    input  logic                                i_last_pixel,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [wcl_pkg::COLOR_WIDTH-1:0]     o_color,
    output logic [1:0]                          o_region,
    output logic                                o_last_out
);
    import wcl_pkg::*;

    localparam int QW  = 1 + 2 + 1 + DATA_BITS + PALETTE_BITS + COLOR_WIDTH;
    localparam int OW  = COLOR_WIDTH + 2 + 1;
    localparam int QCW = $clog2(WCL_QUEUE_DEPTH + 1);
    localparam int OCW = $clog2(WCL_OUT_DEPTH + 1);

    t_cfg_wr                 cfg;

    logic                    f_push;
    logic                    f_write;
    t_region                 f_region;
    logic                    f_last;
    logic [DATA_BITS-1:0]    f_diff;
    logic [PALETTE_BITS-1:0] f_addr;
    logic [COLOR_WIDTH-1:0]  f_color;

    logic [QW-1:0]           q_in;
    logic [QW-1:0]           q_out;
    t_fifo_status            q_status;
    logic [QCW-1:0]          q_count;
    logic                    q_pop;

    logic                    b_write;
    logic [1:0]              b_region_bits;
    logic                    b_last;
    logic [DATA_BITS-1:0]    b_diff;
    logic [PALETTE_BITS-1:0] b_addr;
    logic [COLOR_WIDTH-1:0]  b_color;

    logic                    r_valid;
    logic [COLOR_WIDTH-1:0]  r_color;
    t_region                 r_region;
    logic                    r_last;

    logic [OW-1:0]           o_in;
    logic [OW-1:0]           o_out;
    t_fifo_status            o_status_buf;
    logic [OCW-1:0]          o_count_buf;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    wcl_front #(
        .DATA_BITS    (DATA_BITS),
        .PALETTE_BITS (PALETTE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_sample      (i_sample),
        .i_entry_index (i_entry_index),
        .i_entry_color (i_entry_color),
        .i_last_pixel  (i_last_pixel),
        .o_push        (f_push),
        .i_full        (q_status.full),
        .o_write       (f_write),
        .o_region      (f_region),
        .o_last        (f_last),
        .o_diff        (f_diff),
        .o_addr        (f_addr),
        .o_color       (f_color)
    );

    assign q_in = {f_write, f_region, f_last, f_diff, f_addr, f_color};

    wcl_fifo #(
        .WIDTH (QW),
        .DEPTH (WCL_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (f_push),
        .i_data   (q_in),
        .i_pop    (q_pop),
        .o_data   (q_out),
        .o_status (q_status),
        .o_count  (q_count)
    );

    assign {b_write, b_region_bits, b_last, b_diff, b_addr, b_color} = q_out;

    wcl_back #(
        .DATA_BITS    (DATA_BITS),
        .PALETTE_BITS (PALETTE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_empty     (q_status.empty || (q_count == '0)),
        .o_pop       (q_pop),
        .i_write     (b_write),
        .i_region    (t_region'(b_region_bits)),
        .i_last      (b_last),
        .i_diff      (b_diff),
        .i_addr      (b_addr),
        .i_color     (b_color),
        .i_out_count (o_count_buf),
        .o_valid     (r_valid),
        .o_color     (r_color),
        .o_region    (r_region),
        .o_last      (r_last)
    );

    assign o_in = {r_color, r_region, r_last};

    wcl_fifo #(
        .WIDTH (OW),
        .DEPTH (WCL_OUT_DEPTH)
    ) u_results (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (r_valid),
        .i_data   (o_in),
        .i_pop    (!i_stall),
        .o_data   (o_out),
        .o_status (o_status_buf),
        .o_count  (o_count_buf)
    );

    assign o_valid                           = !o_status_buf.empty;
    assign {o_color, o_region, o_last_out}   = o_out;

endmodule

// File: rtl/core/wcl_checker.sv
// Port-level checker of the windowed colormap lookup, bound to the top level.
// Depends on wcl_pkg and windowed_colormap_lookup_macros.svh.
`include "windowed_colormap_lookup_macros.svh"

module wcl_checker #(
    parameter int PALETTE_BITS = wcl_pkg::WCL_PALETTE_BITS,
    parameter int DATA_BITS    = wcl_pkg::WCL_DATA_BITS
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            i_mode,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [wcl_pkg::COLOR_WIDTH-1:0] o_color,
    input logic [1:0]                      o_region,
    input logic                            o_last_out
);
    import wcl_pkg::*;

    // Input register, queue, three back-end stages and the result buffer.
    localparam int MAX_PENDING = 1 + WCL_QUEUE_DEPTH + 3 + WCL_OUT_DEPTH;
    localparam int PCW         = $clog2(MAX_PENDING + 2);

    logic [PCW-1:0] r_pending;
    logic           pix_in;
    logic           res_out;

    assign pix_in  = i_valid && !o_stall && !i_mode;
    assign res_out = o_valid && !i_stall;

    // Pixels taken whose result has not yet been delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + PCW'(pix_in) - PCW'(res_out);
        end
    end

    `WCL_ASSERT_NEXT(a_result_holds, o_valid && i_stall, o_valid && $stable({o_color, o_region, o_last_out}), "stalled result changed")
    `WCL_ASSERT_RESET(a_reset_empty, !o_valid, "result offered right after reset")
    `WCL_ASSERT_NOW(a_no_spurious, !res_out || (r_pending != '0), "result without a pending pixel")
    `WCL_ASSERT_NOW(a_bounded, r_pending <= PCW'(MAX_PENDING), "more pixels in flight than storage")

endmodule

bind windowed_colormap_lookup wcl_checker #(
    .PALETTE_BITS (PALETTE_BITS),
    .DATA_BITS    (DATA_BITS)
) u_wcl_checker (.*);
